/* hw/rtl/apla_pkg.sv */
// Shared constants and types for the adjacent pair lock arbiter.
package apla_pkg;

  localparam int MAX_SEATS_DEF = 16;
  localparam int MAX_RESULTS   = 8;
  localparam int SEAT_W        = 5;
  localparam int NUM_W         = 5;
  localparam int GCNT_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [NUM_W-1:0] NUM_SEATS_RST = NUM_W'(16);

  typedef enum logic [1:0] {
    EV_GRANT   = 2'd0,
    EV_QUEUED  = 2'd1,
    EV_NOGRANT = 2'd2,
    EV_REJECT  = 2'd3
  } ev_t;

  typedef enum logic [0:0] {
    CMD_GRAB    = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

endpackage

/* hw/rtl/adjacent_pair_lock_arbiter_top.sv */
// An out-of-range seat is rejected straight from idle; a grab first reduces the seat mod N.
// A release frees the pair, then rescans the wait list one entry at a time through one shared
// compare/subtract unit.
// The block takes one item at a time; busy drops in the cycle that carries the final result.
// Results come one per strobe cycle and cannot be stalled by the receiver.
// Synchronous reset: all resources free, wait list empty, num_seats = 16.
module adjacent_pair_lock_arbiter_top #(
  parameter int MAX_SEATS = apla_pkg::MAX_SEATS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [apla_pkg::SEAT_W-1:0]   seat,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [apla_pkg::NUM_W-1:0]    cfg_data,
  output logic                          result_strobe,
  output apla_pkg::ev_t                 event_res,
  output logic [apla_pkg::SEAT_W-1:0]   granted_seat,
  output logic                          last
);
  import apla_pkg::*;

  localparam int AW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
  localparam int CW = $clog2(MAX_SEATS + 1);
  localparam logic [MAX_SEATS-1:0] ONE     = MAX_SEATS'(1);
  localparam logic [MAX_SEATS-1:0] ALL_ONE = {MAX_SEATS{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SEAT_MOD  = 5'b00010,
    ST_SCAN_RD   = 5'b00100,
    ST_SCAN_LOAD = 5'b01000,
    ST_SCAN_MOD  = 5'b10000
  } state_t;

  state_t                state;
  logic [NUM_W-1:0]      num_seats;
  logic [MAX_SEATS-1:0]  resource_free;
  logic [CW-1:0]         wait_count;
  logic [CW-1:0]         rd_idx;
  logic [CW-1:0]         keep_idx;
  logic [GCNT_W-1:0]     grant_cnt;
  logic                  pend_valid;
  logic [SEAT_W-1:0]     pend_seat;
  logic                  cur_cmd;
  logic [SEAT_W-1:0]     cur_seat;
  logic [SEAT_W-1:0]     rem;
  logic [SEAT_W-1:0]     rd_data;

  logic [SEAT_W-1:0]     wait_list [MAX_SEATS];

  logic [SEAT_W-1:0]     n_now;
  logic                  rem_ge;
  logic [SEAT_W-1:0]     rem_sub;
  logic [MAX_SEATS-1:0]  pair_mask;
  logic                  pair_free;
  logic                  seat_bad;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;

  // Saturate the ring size to 2..MAX_SEATS.
  always_comb begin
    if (num_seats < NUM_W'(2)) begin
      n_now = SEAT_W'(2);
    end else if (32'(num_seats) > MAX_SEATS) begin
      n_now = SEAT_W'(MAX_SEATS);
    end else begin
      n_now = num_seats;
    end
  end

  // Shared unit: one compare/subtract step of (seat mod N) per cycle.
  assign rem_ge    = (rem >= n_now);
  assign rem_sub   = rem - n_now;
  assign pair_mask = (ONE << SEAT_W'(cur_seat - SEAT_W'(1))) | (ONE << rem);
  assign pair_free = ((resource_free & pair_mask) == pair_mask);
  assign seat_bad  = (seat == '0) || (seat > n_now);

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wait_count[AW-1:0];
    if (state == ST_SEAT_MOD && !rem_ge && cur_cmd == CMD_GRAB && !pair_free &&
        32'(wait_count) < MAX_SEATS) begin
      mem_we = 1'b1;
    end else if (state == ST_SCAN_MOD && !rem_ge &&
                 !(32'(grant_cnt) < MAX_RESULTS && pair_free)) begin
      mem_we    = 1'b1;
      mem_waddr = keep_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wait_list[mem_waddr] <= cur_seat;
    end
    rd_data <= wait_list[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      num_seats     <= NUM_SEATS_RST;
      resource_free <= ALL_ONE;
      wait_count    <= '0;
      rd_idx        <= '0;
      keep_idx      <= '0;
      grant_cnt     <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        num_seats <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur_cmd  <= cmd;
            cur_seat <= seat;
            rem      <= seat;
            if (seat_bad) begin
              result_strobe <= 1'b1;
              event_res     <= EV_REJECT;
              granted_seat  <= seat;
              last          <= 1'b1;
            end else begin
              state <= ST_SEAT_MOD;
            end
          end
        end
        ST_SEAT_MOD: begin
          if (rem_ge) begin
            rem <= rem_sub;
          end else if (cur_cmd == CMD_GRAB) begin
            result_strobe <= 1'b1;
            granted_seat  <= cur_seat;
            last          <= 1'b1;
            state         <= ST_IDLE;
            if (pair_free) begin
              resource_free <= resource_free & ~pair_mask;
              event_res     <= EV_GRANT;
            end else if (32'(wait_count) >= MAX_SEATS) begin
              event_res <= EV_REJECT;
            end else begin
              wait_count <= wait_count + CW'(1);
              event_res  <= EV_QUEUED;
            end
          end else begin
            resource_free <= resource_free | pair_mask;
            rd_idx        <= '0;
            keep_idx      <= '0;
            grant_cnt     <= '0;
            pend_valid    <= 1'b0;
            state         <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: begin
          if (rd_idx < wait_count) begin
            state <= ST_SCAN_LOAD;
          end else begin
            // Flush the held grant as the final beat, or report no grant.
            wait_count    <= keep_idx;
            result_strobe <= 1'b1;
            last          <= 1'b1;
            if (pend_valid) begin
              event_res    <= EV_GRANT;
              granted_seat <= pend_seat;
            end else begin
              event_res    <= EV_NOGRANT;
              granted_seat <= '0;
            end
            state <= ST_IDLE;
          end
        end
        ST_SCAN_LOAD: begin
          cur_seat <= rd_data;
          rem      <= rd_data;
          state    <= ST_SCAN_MOD;
        end
        ST_SCAN_MOD: begin
          if (rem_ge) begin
            rem <= rem_sub;
          end else begin
            if (32'(grant_cnt) < MAX_RESULTS && pair_free) begin
              resource_free <= resource_free & ~pair_mask;
              // Hold each grant one step so the final one can carry last.
              if (pend_valid) begin
                result_strobe <= 1'b1;
                event_res     <= EV_GRANT;
                granted_seat  <= pend_seat;
                last          <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_seat  <= cur_seat;
              grant_cnt  <= grant_cnt + GCNT_W'(1);
            end else begin
              keep_idx <= keep_idx + CW'(1);
            end
            rd_idx <= rd_idx + CW'(1);
            state  <= ST_SCAN_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_wait_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wait_count) <= MAX_SEATS)
    else $error("wait list count above capacity");

  a_keep_behind_read: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_SEAT_MOD) |-> (keep_idx <= rd_idx))
    else $error("compaction index passed read index");

  a_grant_limit: assert property (@(posedge clk) disable iff (rst)
    32'(grant_cnt) <= MAX_RESULTS)
    else $error("grant count above result limit");

  a_nogrant_form: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && event_res == EV_NOGRANT) |-> (granted_seat == '0 && last))
    else $error("no-grant result malformed");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last && $past(busy)) |-> !busy)
    else $error("final result while still busy");

endmodule

/* verif/apla_checker.sv */
// Checker for the adjacent pair lock arbiter: tracks the ring, predicts each result, compares.
`timescale 1ns / 100ps

module apla_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        cmd,
  input  logic [apla_pkg::SEAT_W-1:0] seat,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [apla_pkg::NUM_W-1:0]  cfg_data,
  input  logic                        result_strobe,
  input  apla_pkg::ev_t               event_res,
  input  logic [apla_pkg::SEAT_W-1:0] granted_seat,
  input  logic                        last,
  output int                          fail_count,
  output int                          outstanding,
  output int                          results_seen,
  output int                          grants_seen
);
  import apla_pkg::*;

  localparam int RING_MAX = MAX_SEATS_DEF;

  typedef struct packed {
    ev_t               ev;
    logic [SEAT_W-1:0] who;
    logic              fin;
  } outcome_t;

  logic [RING_MAX-1:0] free_res;
  logic [SEAT_W-1:0]   waiters[$];
  logic [NUM_W-1:0]    seats_reg;
  outcome_t            expected_q[$];

  function automatic int ring_size();
    if (seats_reg < 2) return 2;
    if (seats_reg > RING_MAX) return RING_MAX;
    return int'(seats_reg);
  endfunction

  function automatic logic [RING_MAX-1:0] pair_of(input int s, input int n);
    logic [RING_MAX-1:0] m;
    m = '0;
    m[(s - 1) % RING_MAX] = 1'b1;
    m[(s % n) % RING_MAX] = 1'b1;
    return m;
  endfunction

  function automatic void add_outcome(input ev_t e, input logic [SEAT_W-1:0] w,
                                      input logic f);
    outcome_t o;
    o.ev  = e;
    o.who = w;
    o.fin = f;
    expected_q = {expected_q, o};
  endfunction

  function automatic void predict_outcomes(input cmd_t c, input logic [SEAT_W-1:0] s);
    int                  n;
    int                  granted;
    logic [RING_MAX-1:0] m;
    logic [RING_MAX-1:0] wm;
    logic [SEAT_W-1:0]   kept[$];
    n = ring_size();
    if (s == 0 || int'(s) > n) begin
      add_outcome(EV_REJECT, s, 1'b1);
      return;
    end
    m = pair_of(int'(s), n);
    if (c == CMD_GRAB) begin
      if ((free_res & m) == m) begin
        free_res &= ~m;
        add_outcome(EV_GRANT, s, 1'b1);
      end else if (waiters.size() >= RING_MAX) begin
        add_outcome(EV_REJECT, s, 1'b1);
      end else begin
        waiters = {waiters, s};
        add_outcome(EV_QUEUED, s, 1'b1);
      end
      return;
    end
    // release frees the pair even when the seat held nothing, then rescans in order
    free_res |= m;
    granted = 0;
    foreach (waiters[i]) begin
      wm = pair_of(int'(waiters[i]), n);
      if (granted < MAX_RESULTS && (free_res & wm) == wm) begin
        free_res &= ~wm;
        add_outcome(EV_GRANT, waiters[i], 1'b0);
        granted++;
      end else begin
        kept = {kept, waiters[i]};
      end
    end
    waiters = kept;
    if (granted == 0) add_outcome(EV_NOGRANT, '0, 1'b1);
    else expected_q[expected_q.size() - 1].fin = 1'b1;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      free_res = '1;
      waiters.delete();
      seats_reg = NUM_SEATS_RST;
      expected_q.delete();
      fail_count   = 0;
      results_seen = 0;
      grants_seen  = 0;
    end else begin
      if (result_strobe) begin
        results_seen++;
        if (event_res == EV_GRANT) grants_seen++;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result ev=%s seat=%0d last=%0b, expected none",
                   $time, event_res.name(), granted_seat, last);
        end else begin
          want = expected_q.pop_front();
          if (want.ev !== event_res || want.who !== granted_seat || want.fin !== last) begin
            fail_count++;
            $display("%0t: mismatch: expected ev=%s seat=%0d last=%0b, got ev=%s seat=%0d last=%0b",
                     $time, want.ev.name(), want.who, want.fin,
                     event_res.name(), granted_seat, last);
          end
        end
      end
      // a command taken at the same edge still sees the old ring size
      if (start && !busy) predict_outcomes(cmd_t'(cmd), seat);
      if (cfg_valid && cfg_ready) seats_reg = cfg_data;
    end
    outstanding = expected_q.size();
  end

endmodule

/* verif/testbench.sv */
// Stimulus and verdict for the adjacent pair lock arbiter.
`timescale 1ns / 100ps

module testbench;
  import apla_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd = 1'b0;
  logic [SEAT_W-1:0] seat = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NUM_W-1:0]  cfg_data = '0;
  logic              result_strobe;
  ev_t               event_res;
  logic [SEAT_W-1:0] granted_seat;
  logic              last;

  int fail_count;
  int outstanding;
  int results_seen;
  int grants_seen;
  int items_sent = 0;
  int ring_writes = 0;
  int ring_now = 16;
  bit no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adjacent_pair_lock_arbiter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .seat          (seat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .event_res     (event_res),
    .granted_seat  (granted_seat),
    .last          (last)
  );

  apla_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .seat          (seat),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .event_res     (event_res),
    .granted_seat  (granted_seat),
    .last          (last),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .grants_seen   (grants_seen)
  );

  // Hold start until the arbiter takes the beat.
  task automatic send_item(input cmd_t c, input logic [SEAT_W-1:0] s);
    start <= 1'b1;
    cmd   <= c;
    seat  <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle_gap();
    int g;
    g = 0;
    if (!no_gaps) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: g = 0;
        6, 7, 8:          g = $urandom_range(3, 1);
        default:          g = $urandom_range(40, 10);
      endcase
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop start and wait until every predicted result is out.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ring(input logic [NUM_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ring_writes++;
    ring_now = (v < 2) ? 2 : (v > 16) ? 16 : int'(v);
  endtask

  task automatic random_item(input int grab_pct);
    cmd_t              c;
    logic [SEAT_W-1:0] s;
    c = ($urandom_range(99) < grab_pct) ? CMD_GRAB : CMD_RELEASE;
    if ($urandom_range(9) == 0) s = SEAT_W'($urandom_range(31));
    else s = SEAT_W'($urandom_range(ring_now, 1));
    send_item(c, s);
    idle_gap();
  endtask

  initial begin
    logic [NUM_W-1:0] ring_plan[8];
    int               grab_pct;
    ring_plan = '{5'd31, 5'd2, 5'd16, 5'd1, 5'd17, 5'd3, 5'd0, 5'd16};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // out-of-range seats, grant, queue, release rescans, foreign release
    send_item(CMD_GRAB, 5'd0);
    send_item(CMD_RELEASE, 5'd31);
    send_item(CMD_GRAB, 5'd17);
    send_item(CMD_GRAB, 5'd1);
    send_item(CMD_GRAB, 5'd2);
    send_item(CMD_GRAB, 5'd16);
    send_item(CMD_GRAB, 5'd3);
    send_item(CMD_RELEASE, 5'd1);
    send_item(CMD_RELEASE, 5'd3);
    send_item(CMD_RELEASE, 5'd5);
    // ring of two, pair blocked: duplicates fill the wait list, then one overflows
    write_ring(5'd0);
    for (int i = 0; i < 17; i++) send_item(CMD_GRAB, 5'd2);

    for (int p = 0; p < 8; p++) begin
      write_ring((p == 5) ? NUM_W'($urandom_range(15, 3)) : ring_plan[p]);
      grab_pct = $urandom_range(85, 40);
      no_gaps = ($urandom_range(3) == 0);
      for (int i = 0; i < 15; i++) begin
        random_item(grab_pct);
        if ($urandom_range(19) == 0) drain();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("Sent %0d commands over %0d ring-size writes; %0d results checked, %0d grants.",
             items_sent, ring_writes, results_seen, grants_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", outstanding);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* adjacent_pair_lock_arbiter_top.f */
hw/rtl/apla_pkg.sv
hw/rtl/adjacent_pair_lock_arbiter_top.sv
verif/apla_checker.sv
verif/testbench.sv
